[hdl/canfd_message_header_codec_defines.svh]
// assertion macros for the can fd message header codec
`ifndef CANFD_MESSAGE_HEADER_CODEC_DEFINES_SVH
`define CANFD_MESSAGE_HEADER_CODEC_DEFINES_SVH

`ifndef SYNTH
`define CFDHC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
`define CFDHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next cycle check failed");
`else
`define CFDHC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define CFDHC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hdl/cfdhc_pkg.sv]
// types, constants and lookup functions of the can fd message header codec
package cfdhc_pkg;

   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 80;
   localparam int ID_W       = 29;
   localparam int BASE_W     = 11;
   localparam int EXT_LOW_W  = 18;
   localparam int LEN_W      = 7;
   localparam int DLC_W      = 4;
   localparam int FLAGS_W    = 8;
   localparam int WORD_W     = 32;
   localparam int DLC_CODES  = 16;

   localparam logic [LEN_W-1:0] CLASSIC_MAX_LEN = 7'd8;

   localparam logic [LEN_W-1:0] DLC_LEN [DLC_CODES] = '{
      7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7,
      7'd8, 7'd12, 7'd16, 7'd20, 7'd24, 7'd32, 7'd48, 7'd64
   };

   // flag byte bit positions
   localparam int FLAG_IDE_BIT = 4;
   localparam int FLAG_RTR_BIT = 5;
   localparam int FLAG_BRS_BIT = 6;
   localparam int FLAG_FDF_BIT = 7;

   typedef enum logic {
      ACT_ENCODE = 1'b0,
      ACT_DECODE = 1'b1
   } action_type;

   typedef struct packed {
      logic             found;
      logic [DLC_W-1:0] dlc;
   } dlc_lookup_type;

   typedef struct packed {
      action_type       action;
      logic [ID_W-1:0]  id;
      logic             ext;
      logic             brs;
      logic             fd;
      logic             enc_ok;
      logic [DLC_W-1:0] dlc;
      logic [ID_W-1:0]  dec_id;
      logic             dec_ext;
      logic             dec_rtr;
      logic             dec_brs;
      logic             dec_fd;
      logic [LEN_W-1:0] dec_len;
   } s1_type;

   typedef struct packed {
      action_type         action;
      logic               enc_ok;
      logic [ID_W-1:0]    enc_word;
      logic [FLAGS_W-1:0] enc_flags;
      logic [ID_W-1:0]    dec_id;
      logic               dec_ext;
      logic               dec_rtr;
      logic               dec_brs;
      logic               dec_fd;
      logic [LEN_W-1:0]   dec_len;
   } s2_type;

   function automatic dlc_lookup_type len_to_dlc(input logic [LEN_W-1:0] len);
      dlc_lookup_type r;
      r = '0;
      for (int i = 0; i < DLC_CODES; i++) begin
         if (DLC_LEN[i] == len) begin
            r.found = 1'b1;
            r.dlc   = DLC_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] dlc_to_len(input logic [DLC_W-1:0] dlc);
      return DLC_LEN[dlc];
   endfunction

endpackage

[hdl/canfd_message_header_codec.sv]
// can fd message header codec top level, three stage pipeline
//
//  channel  dir  ports                    contents
//  req      in   req_tdata, req_tuser     frame header or object header
//  rsp      out  rsp_tdata                encode or decode result
//
// one transaction per cycle sustained while rsp_tready is high
// stages: table lookup and checks, id swap and flag pack, result select
// each stage advances when empty or when the next one advances
// a stalled rsp fills empty stages before req_tready drops
// reset clears the stage valid bits only
`include "canfd_message_header_codec_defines.svh"

module canfd_message_header_codec (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // frame_id[28:0], is_extended[29], is_remote[30], use_brs[31], is_fd[32],
   // payload_length[39:33], object_id_word[71:40], object_flags[79:72]
   input  logic [cfdhc_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[0]
   input  logic [cfdhc_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // accepted[0], header_id_word[29:1], header_flags[37:30], decoded_id[66:38],
   // decoded_extended[67], decoded_remote[68], decoded_brs[69], decoded_fd[70],
   // decoded_length[77:71], zero[79:78]
   output logic [cfdhc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import cfdhc_pkg::*;

   logic                  s1_v_ff, s1_v_in;
   logic                  s2_v_ff, s2_v_in;
   logic                  s3_v_ff, s3_v_in;
   logic                  s1_adv, s2_adv, s3_adv;
   s1_type                s1_ff, s1_in;
   s2_type                s2_ff, s2_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [ID_W-1:0]    in_id;
   logic               in_ext, in_rtr, in_brs, in_fd;
   logic [LEN_W-1:0]   in_len;
   logic [WORD_W-1:0]  in_raw;
   logic [FLAGS_W-1:0] in_flags;
   dlc_lookup_type     lk;
   logic [LEN_W-1:0]   dec_len_full;

   assign s3_adv     = !s3_v_ff || rsp_tready;
   assign s2_adv     = !s2_v_ff || s3_adv;
   assign s1_adv     = !s1_v_ff || s2_adv;
   assign req_tready = s1_adv;
   assign rsp_tvalid = s3_v_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign s1_v_in = s1_adv ? req_tvalid : s1_v_ff;
   assign s2_v_in = s2_adv ? s1_v_ff : s2_v_ff;
   assign s3_v_in = s3_adv ? s2_v_ff : s3_v_ff;

   // stage one: field checks, length to dlc, object header unpack
   assign in_id    = req_tdata[28:0];
   assign in_ext   = req_tdata[29];
   assign in_rtr   = req_tdata[30];
   assign in_brs   = req_tdata[31];
   assign in_fd    = req_tdata[32];
   assign in_len   = req_tdata[39:33];
   assign in_raw   = req_tdata[71:40];
   assign in_flags = req_tdata[79:72];

   always_comb begin
      lk           = len_to_dlc(in_len);
      dec_len_full = dlc_to_len(in_flags[DLC_W-1:0]);
      s1_in.action = action_type'(req_tuser[0]);
      s1_in.id     = in_id;
      s1_in.ext    = in_ext;
      s1_in.brs    = in_brs;
      s1_in.fd     = in_fd;
      s1_in.dlc    = lk.dlc;
      s1_in.enc_ok = !in_rtr
                     && (in_ext || (in_id[ID_W-1:BASE_W] == '0))
                     && (in_fd || (!in_brs && (in_len <= CLASSIC_MAX_LEN)))
                     && lk.found;
      s1_in.dec_ext = in_flags[FLAG_IDE_BIT];
      s1_in.dec_rtr = in_flags[FLAG_RTR_BIT];
      s1_in.dec_brs = in_flags[FLAG_BRS_BIT];
      s1_in.dec_fd  = in_flags[FLAG_FDF_BIT];
      if (in_flags[FLAG_IDE_BIT]) begin
         s1_in.dec_id = {in_raw[BASE_W-1:0], in_raw[BASE_W +: EXT_LOW_W]};
      end else begin
         s1_in.dec_id = {{EXT_LOW_W{1'b0}}, in_raw[BASE_W-1:0]};
      end
      if (!in_flags[FLAG_FDF_BIT] && (dec_len_full > CLASSIC_MAX_LEN)) begin
         s1_in.dec_len = CLASSIC_MAX_LEN;
      end else begin
         s1_in.dec_len = dec_len_full;
      end
   end

   // stage two: id swap and flag byte pack
   always_comb begin
      s2_in.action = s1_ff.action;
      s2_in.enc_ok = s1_ff.enc_ok;
      if (s1_ff.ext) begin
         s2_in.enc_word = {s1_ff.id[EXT_LOW_W-1:0], s1_ff.id[ID_W-1:EXT_LOW_W]};
      end else begin
         s2_in.enc_word = s1_ff.id;
      end
      s2_in.enc_flags = {s1_ff.fd, s1_ff.brs, 1'b0, s1_ff.ext, s1_ff.dlc};
      s2_in.dec_id    = s1_ff.dec_id;
      s2_in.dec_ext   = s1_ff.dec_ext;
      s2_in.dec_rtr   = s1_ff.dec_rtr;
      s2_in.dec_brs   = s1_ff.dec_brs;
      s2_in.dec_fd    = s1_ff.dec_fd;
      s2_in.dec_len   = s1_ff.dec_len;
   end

   // stage three: result select, unused mode zeroed
   always_comb begin
      rsp_data_in = '0;
      unique case (s2_ff.action)
         ACT_ENCODE: begin
            rsp_data_in[0] = s2_ff.enc_ok;
            if (s2_ff.enc_ok) begin
               rsp_data_in[29:1]  = s2_ff.enc_word;
               rsp_data_in[37:30] = s2_ff.enc_flags;
            end
         end
         ACT_DECODE: begin
            rsp_data_in[0]     = 1'b1;
            rsp_data_in[66:38] = s2_ff.dec_id;
            rsp_data_in[67]    = s2_ff.dec_ext;
            rsp_data_in[68]    = s2_ff.dec_rtr;
            rsp_data_in[69]    = s2_ff.dec_brs;
            rsp_data_in[70]    = s2_ff.dec_fd;
            rsp_data_in[77:71] = s2_ff.dec_len;
         end
         default: rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && req_tvalid) begin
         s1_ff <= s1_in;
      end
      if (s2_adv && s1_v_ff) begin
         s2_ff <= s2_in;
      end
      if (s3_adv && s2_v_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `CFDHC_ASSERT_NEXT(a_s1_hold, clock, reset, s1_v_ff && !s2_adv, s1_v_ff && $stable(s1_ff))
   `CFDHC_ASSERT_NEXT(a_s2_hold, clock, reset, s2_v_ff && !s3_adv, s2_v_ff && $stable(s2_ff))
   `CFDHC_ASSERT_IMPLIES(a_reject_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[79:1] == '0)
   `CFDHC_ASSERT_IMPLIES(a_classic_len, clock, reset, rsp_tvalid && !rsp_tdata[70], rsp_tdata[77:71] <= CLASSIC_MAX_LEN)
   `CFDHC_ASSERT_IMPLIES(a_mode_excl, clock, reset, rsp_tvalid && (rsp_tdata[37:1] != '0), rsp_tdata[77:38] == '0)

endmodule

[sim/canfd_message_header_codec_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for the can fd message header codec, directed and random encode/decode
module canfd_message_header_codec_test;
   import cfdhc_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   localparam int QUIET_ITEMS  = 200;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_LIMIT  = 20;

   // one request transaction, action on top so the low bits match req_tdata
   typedef struct packed {
      action_type         action;
      logic [FLAGS_W-1:0] obj_flags;
      logic [WORD_W-1:0]  obj_word;
      logic [LEN_W-1:0]   len;
      logic               fd;
      logic               brs;
      logic               rtr;
      logic               ext;
      logic [ID_W-1:0]    frame_id;
   } hdr_job_type;

   // one response transaction, same layout as rsp_tdata
   typedef struct packed {
      logic [1:0]         pad;
      logic [LEN_W-1:0]   dec_len;
      logic               dec_fd;
      logic               dec_brs;
      logic               dec_rtr;
      logic               dec_ext;
      logic [ID_W-1:0]    dec_id;
      logic [FLAGS_W-1:0] hdr_flags;
      logic [ID_W-1:0]    hdr_word;
      logic               accepted;
   } hdr_result_type;

   class header_scoreboard;
      hdr_result_type pending_results[$];
      int mismatches = 0;
      int checked    = 0;
      int enc_ok     = 0;
      int enc_reject = 0;
      int decodes    = 0;

      static function logic [LEN_W-1:0] dlc_bytes(input logic [DLC_W-1:0] code);
         case (code)
            4'd9:    return 7'd12;
            4'd10:   return 7'd16;
            4'd11:   return 7'd20;
            4'd12:   return 7'd24;
            4'd13:   return 7'd32;
            4'd14:   return 7'd48;
            4'd15:   return 7'd64;
            default: return {3'b000, code};
         endcase
      endfunction

      function hdr_result_type predict_header(input hdr_job_type j);
         hdr_result_type e;
         logic [DLC_W-1:0] code;
         logic hit;
         e = '0;
         code = '0;
         hit = 1'b0;
         if (j.action == ACT_ENCODE) begin
            for (int i = 0; i < DLC_CODES; i++) begin
               if (dlc_bytes(DLC_W'(i)) == j.len) begin
                  hit = 1'b1;
                  code = DLC_W'(i);
               end
            end
            if (!j.rtr && hit && (j.ext || j.frame_id <= 29'h7FF) &&
                (j.fd || (j.len <= 7'd8 && !j.brs))) begin
               e.accepted = 1'b1;
               e.hdr_word = j.ext ? {j.frame_id[17:0], j.frame_id[28:18]} : j.frame_id;
               e.hdr_flags = {j.fd, j.brs, 1'b0, j.ext, code};
            end
         end else begin
            e.accepted = 1'b1;
            e.dec_ext = j.obj_flags[FLAG_IDE_BIT];
            e.dec_rtr = j.obj_flags[FLAG_RTR_BIT];
            e.dec_brs = j.obj_flags[FLAG_BRS_BIT];
            e.dec_fd  = j.obj_flags[FLAG_FDF_BIT];
            e.dec_id  = e.dec_ext ? {j.obj_word[10:0], j.obj_word[28:11]}
                                  : {18'd0, j.obj_word[10:0]};
            e.dec_len = dlc_bytes(j.obj_flags[3:0]);
            if (!e.dec_fd && e.dec_len > 7'd8) e.dec_len = 7'd8;
         end
         return e;
      endfunction

      task note_request(input hdr_job_type j);
         hdr_result_type e;
         e = predict_header(j);
         pending_results.push_back(e);
         if (j.action == ACT_DECODE) decodes++;
         else if (e.accepted) enc_ok++;
         else enc_reject++;
      endtask

      task report(input string what);
         mismatches++;
         if (mismatches <= PRINT_LIMIT) $display("mismatch at result %0d: %s", checked, what);
      endtask

      task compare(input string name, input logic [31:0] got, input logic [31:0] want);
         if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_result(input logic [RSP_DATA_W-1:0] data);
         hdr_result_type got;
         hdr_result_type want;
         got = data;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected response %h", data));
         end else begin
            want = pending_results.pop_front();
            compare("accepted", got.accepted, want.accepted);
            compare("header_id_word", got.hdr_word, want.hdr_word);
            compare("header_flags", got.hdr_flags, want.hdr_flags);
            compare("decoded_id", got.dec_id, want.dec_id);
            compare("decoded_extended", got.dec_ext, want.dec_ext);
            compare("decoded_remote", got.dec_rtr, want.dec_rtr);
            compare("decoded_brs", got.dec_brs, want.dec_brs);
            compare("decoded_fd", got.dec_fd, want.dec_fd);
            compare("decoded_length", got.dec_len, want.dec_len);
            compare("pad", got.pad, want.pad);
         end
         checked++;
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   header_scoreboard sb = new();
   bit quiet = 1'b0;
   bit hold_req = 1'b0;
   int cycle_count = 0;

   canfd_message_header_codec uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request({action_type'(req_tuser[0]), req_tdata});
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // response side: random stalls, one long hold-off on request
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 8);
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   function automatic hdr_job_type noise_job();
      hdr_job_type j;
      j.action    = action_type'(1'($urandom));
      j.obj_flags = FLAGS_W'($urandom);
      j.obj_word  = $urandom;
      j.len       = LEN_W'($urandom);
      j.fd        = 1'($urandom);
      j.brs       = 1'($urandom);
      j.rtr       = 1'($urandom);
      j.ext       = 1'($urandom);
      j.frame_id  = ID_W'($urandom);
      return j;
   endfunction

   function automatic hdr_job_type encode_job(input logic [ID_W-1:0] id, input logic ext,
                                              input logic rtr, input logic brs, input logic fd,
                                              input logic [LEN_W-1:0] len);
      hdr_job_type j;
      j = noise_job();
      j.action = ACT_ENCODE;
      j.frame_id = id;
      j.ext = ext;
      j.rtr = rtr;
      j.brs = brs;
      j.fd = fd;
      j.len = len;
      return j;
   endfunction

   function automatic hdr_job_type decode_job(input logic [WORD_W-1:0] word,
                                              input logic [FLAGS_W-1:0] flags);
      hdr_job_type j;
      j = noise_job();
      j.action = ACT_DECODE;
      j.obj_word = word;
      j.obj_flags = flags;
      return j;
   endfunction

   // mostly well-formed encodes, some broken ones, decodes with random content
   function automatic hdr_job_type random_job();
      hdr_job_type j;
      j = noise_job();
      if ($urandom_range(0, 9) < 6) begin
         j.action = ACT_ENCODE;
         j.rtr = ($urandom_range(0, 9) == 0);
         if (!j.ext && $urandom_range(0, 3) != 0) j.frame_id = ID_W'($urandom_range(0, 'h7FF));
         j.fd = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0)
            j.len = header_scoreboard::dlc_bytes(DLC_W'($urandom_range(0, 15)));
         if (!j.fd && $urandom_range(0, 2) != 0) begin
            j.brs = 1'b0;
            if (j.len > 7'd8) j.len = LEN_W'($urandom_range(0, 8));
         end
      end else begin
         j.action = ACT_DECODE;
      end
      return j;
   endfunction

   task automatic send_item(input hdr_job_type j);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= j[REQ_DATA_W-1:0];
      req_tuser <= j.action;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // encode: identifier and length extremes, each reject reason
      send_item(encode_job(29'h0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0));
      send_item(encode_job(29'h7FF, 1'b0, 1'b0, 1'b0, 1'b0, 7'd8));
      send_item(encode_job(29'h800, 1'b0, 1'b0, 1'b0, 1'b1, 7'd8));
      send_item(encode_job(29'h1FFFFFFF, 1'b1, 1'b0, 1'b1, 1'b1, 7'd64));
      send_item(encode_job(29'h0, 1'b1, 1'b0, 1'b0, 1'b1, 7'd12));
      send_item(encode_job(29'h5, 1'b0, 1'b1, 1'b0, 1'b1, 7'd1));
      send_item(encode_job(29'h123, 1'b0, 1'b0, 1'b0, 1'b0, 7'd12));
      send_item(encode_job(29'h123, 1'b0, 1'b0, 1'b1, 1'b0, 7'd4));
      send_item(encode_job(29'h456, 1'b0, 1'b0, 1'b0, 1'b1, 7'd9));
      send_item(encode_job(29'h456, 1'b1, 1'b0, 1'b0, 1'b1, 7'd65));
      send_item(encode_job(29'h456, 1'b1, 1'b0, 1'b1, 1'b1, 7'd127));
      send_item(encode_job(29'h15555555, 1'b1, 1'b0, 1'b0, 1'b1, 7'd48));
      send_item(encode_job(29'h0ABCDEF, 1'b1, 1'b0, 1'b0, 1'b0, 7'd8));
      send_item(encode_job(29'h7FF, 1'b0, 1'b0, 1'b1, 1'b1, 7'd20));
      send_item(encode_job(29'h1FFFFFFF, 1'b1, 1'b1, 1'b0, 1'b1, 7'd64));
      // decode: masked id bits, remote, classic clamp, all flags
      send_item(decode_job(32'hFFFFFFFF, 8'h00));
      send_item(decode_job(32'hFFFFFFFF, 8'h10));
      send_item(decode_job(32'h00000000, 8'h2F));
      send_item(decode_job(32'hA5A5A5A5, 8'h8F));
      send_item(decode_job(32'hE0000000, 8'hFF));
      send_item(decode_job(32'h1FFFF800, 8'h59));
      send_item(decode_job(32'h12345678, 8'h88));

      // long response hold-off while requests keep coming
      hold_req = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         send_item(random_job());
      end
      req_tvalid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d responses: %0d encodes accepted, %0d encodes rejected, %0d decodes",
               sb.checked, sb.enc_ok, sb.enc_reject, sb.decodes);
      $display("%0d mismatches", sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/cfdhc_pkg.sv
hdl/canfd_message_header_codec.sv
sim/canfd_message_header_codec_test.sv
